@@ sv/motor_current_sense_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Motor current sense filter assertion macros
// Shared concurrent assertion forms used by the filter's top level.
// ----------------------------------------------------------------------------
`ifndef MOTOR_CURRENT_SENSE_FILTER_DEFINES_SVH
`define MOTOR_CURRENT_SENSE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCSF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mcsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor current sense filter package
// Constants, register codes and stage payload types shared by the filter.
// ----------------------------------------------------------------------------
package mcsf_pkg;

  localparam int SAMPLES_PER_READING = 8;
  localparam int NUM_CHANNELS        = 4;
  localparam int NUM_OFF_LEVELS      = 4;

  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 2;
  localparam int GAIN_W   = 16;
  localparam int CUR_W    = 24;
  localparam int OUT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);
  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

  localparam logic [SAMPLE_W:0] OFF_BAND_COUNTS = (SAMPLE_W + 1)'(10);
  localparam logic [CUR_W-1:0]  CURRENT_Q8_MAX  = '1;

  // Reciprocal of five, scaled by two to the power RECIP_SHIFT; exact for
  // numerators below two to the power 27.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 28;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(214748365);
  localparam int MIX_W       = 27;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEG_OFFSET  = 3'd0,
    REG_OFF_CH0     = 3'd1,
    REG_OFF_CH1     = 3'd2,
    REG_OFF_CH2     = 3'd3,
    REG_OFF_CH3     = 3'd4,
    REG_GAIN        = 3'd5,
    REG_SLOW_FILTER = 3'd6
  } cfg_reg_t;

  typedef logic [NUM_OFF_LEVELS-1:0][SAMPLE_W-1:0] off_levels_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] average;
  } avg_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [CUR_W-1:0] current_q8;
    logic             below;
  } cur_item_t;

endpackage

@@ sv/motor_current_sense_filter.sv @@
// ----------------------------------------------------------------------------
// Motor current sense filter
// Averages shunt ADC samples per channel, converts them to milliamps and
// filters the result per channel.
// ----------------------------------------------------------------------------
// The block takes one sample in every clock cycle unless the input is stalled,
// from any mix of the four channels, and each eighth sample of a channel
// completes a reading. The result of a reading is registered after accumulation,
// then after the gain multiplier and then after the filter update into the
// output register, whose divide by five is a reciprocal multiply in the same
// cycle as the filter state read and write. Back-pressure only stalls the input
// once every stage between it and the output register is full.
// ----------------------------------------------------------------------------
`include "motor_current_sense_filter_defines.svh"

module motor_current_sense_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mcsf_pkg::CH_W-1:0]           in_channel,
  input  logic [mcsf_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcsf_pkg::CH_W-1:0]           out_channel,
  output logic [mcsf_pkg::OUT_W-1:0]          out_instant_current,
  output logic [mcsf_pkg::OUT_W-1:0]          out_filtered_current,
  output logic                                out_below_off_level,
  input  logic                                cfg_we,
  input  logic [mcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcsf_pkg::CFG_W-1:0]          cfg_data
);

  logic [mcsf_pkg::SAMPLE_W-1:0] neg_offset_r;
  mcsf_pkg::off_levels_t         off_levels_r;
  logic [mcsf_pkg::GAIN_W-1:0]   gain_r;
  logic                          slow_filter_r;

  logic                avg_valid;
  logic                avg_ready;
  mcsf_pkg::avg_item_t avg_item;
  logic                cur_valid;
  logic                cur_ready;
  mcsf_pkg::cur_item_t cur_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_offset_r  <= '0;
      off_levels_r  <= '0;
      gain_r        <= mcsf_pkg::GAIN_RESET;
      slow_filter_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcsf_pkg::REG_NEG_OFFSET:  neg_offset_r    <= cfg_data[mcsf_pkg::SAMPLE_W-1:0];
        mcsf_pkg::REG_OFF_CH0:     off_levels_r[0] <= cfg_data[mcsf_pkg::SAMPLE_W-1:0];
        mcsf_pkg::REG_OFF_CH1:     off_levels_r[1] <= cfg_data[mcsf_pkg::SAMPLE_W-1:0];
        mcsf_pkg::REG_OFF_CH2:     off_levels_r[2] <= cfg_data[mcsf_pkg::SAMPLE_W-1:0];
        mcsf_pkg::REG_OFF_CH3:     off_levels_r[3] <= cfg_data[mcsf_pkg::SAMPLE_W-1:0];
        mcsf_pkg::REG_GAIN:        gain_r          <= cfg_data[mcsf_pkg::GAIN_W-1:0];
        mcsf_pkg::REG_SLOW_FILTER: slow_filter_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mcsf_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .avg_valid  (avg_valid),
    .avg_item   (avg_item),
    .avg_ready  (avg_ready)
  );

  mcsf_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .avg_valid       (avg_valid),
    .avg_item        (avg_item),
    .avg_ready       (avg_ready),
    .negative_offset (neg_offset_r),
    .off_levels      (off_levels_r),
    .current_gain    (gain_r),
    .cur_valid       (cur_valid),
    .cur_item        (cur_item),
    .cur_ready       (cur_ready)
  );

  mcsf_filter u_filter (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cur_valid            (cur_valid),
    .cur_item             (cur_item),
    .cur_ready            (cur_ready),
    .slow_filter          (slow_filter_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_channel          (out_channel),
    .out_instant_current  (out_instant_current),
    .out_filtered_current (out_filtered_current),
    .out_below_off_level  (out_below_off_level)
  );

  `MCSF_ASSERT_IMP(a_below_means_zero, clk, rst_n, out_valid && out_below_off_level, out_instant_current == '0, "zero-current reading carries a non-zero current")
  `MCSF_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, avg_valid && cur_valid && out_valid, "input stalled while a pipeline stage is empty")
  `MCSF_ASSERT_IMP(a_result_from_scale, clk, rst_n, $rose(out_valid), $past(cur_valid), "result appeared without a scaled reading before it")

endmodule

@@ sv/mcsf_accum.sv @@
// ----------------------------------------------------------------------------
// Sample accumulator
// Sums samples per channel and registers the truncated average of each
// completed reading.
// ----------------------------------------------------------------------------
module mcsf_accum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mcsf_pkg::CH_W-1:0]           in_channel,
  input  logic [mcsf_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                avg_valid,
  output mcsf_pkg::avg_item_t                 avg_item,
  input  logic                                avg_ready
);

  logic [mcsf_pkg::SUM_W-1:0] sum_r [mcsf_pkg::NUM_CHANNELS];
  logic [mcsf_pkg::CNT_W-1:0] count_r [mcsf_pkg::NUM_CHANNELS];
  logic                       valid_r;
  mcsf_pkg::avg_item_t        item_r;

  logic                       ready;
  logic                       take;
  logic                       complete;
  logic [mcsf_pkg::SUM_W-1:0] sum_nxt;
  logic [mcsf_pkg::SUM_W-1:0] quotient;

  assign ready    = !valid_r || avg_ready;
  assign in_stall = !ready;
  assign take     = in_valid && ready &&
                    (32'(in_channel) < mcsf_pkg::NUM_CHANNELS);
  assign sum_nxt  = sum_r[in_channel] + mcsf_pkg::SUM_W'(in_sample);
  assign complete = (count_r[in_channel] ==
                     mcsf_pkg::CNT_W'(mcsf_pkg::SAMPLES_PER_READING - 1));
  assign quotient = sum_nxt / mcsf_pkg::SUM_W'(mcsf_pkg::SAMPLES_PER_READING);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mcsf_pkg::NUM_CHANNELS; k++) begin
        sum_r[k]   <= '0;
        count_r[k] <= '0;
      end
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (complete) begin
          sum_r[in_channel]   <= '0;
          count_r[in_channel] <= '0;
        end else begin
          sum_r[in_channel]   <= sum_nxt;
          count_r[in_channel] <= count_r[in_channel] + mcsf_pkg::CNT_W'(1);
        end
      end
      if (ready) begin
        valid_r <= take && complete;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && complete) begin
      item_r.channel <= in_channel;
      item_r.average <= quotient[mcsf_pkg::SAMPLE_W-1:0];
    end
  end

  assign avg_valid = valid_r;
  assign avg_item  = item_r;

endmodule

@@ sv/mcsf_scale.sv @@
// ----------------------------------------------------------------------------
// Current scaling stage
// Removes the negative-range offset, applies the off-level dead band and
// multiplies the level above the off level by the gain, with saturation.
// ----------------------------------------------------------------------------
module mcsf_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                avg_valid,
  input  mcsf_pkg::avg_item_t                 avg_item,
  output logic                                avg_ready,
  input  logic [mcsf_pkg::SAMPLE_W-1:0]       negative_offset,
  input  mcsf_pkg::off_levels_t               off_levels,
  input  logic [mcsf_pkg::GAIN_W-1:0]         current_gain,
  output logic                                cur_valid,
  output mcsf_pkg::cur_item_t                 cur_item,
  input  logic                                cur_ready
);

  localparam int PROD_W = mcsf_pkg::SAMPLE_W + mcsf_pkg::GAIN_W;

  logic                  valid_r;
  mcsf_pkg::cur_item_t   item_r;
  mcsf_pkg::cur_item_t   item_nxt;

  logic [mcsf_pkg::SAMPLE_W-1:0] off;
  logic [mcsf_pkg::SAMPLE_W-1:0] adj;
  logic [mcsf_pkg::SAMPLE_W-1:0] diff;
  logic [PROD_W-1:0]             prod;
  logic                          pass;

  assign avg_ready = !valid_r || cur_ready;

  always_comb begin
    off  = off_levels[avg_item.channel];
    adj  = avg_item.average - negative_offset;
    diff = adj - off;
    prod = PROD_W'(diff) * PROD_W'(current_gain);
    pass = (avg_item.average > negative_offset) &&
           ({1'b0, adj} >= ({1'b0, off} + mcsf_pkg::OFF_BAND_COUNTS));
    item_nxt.channel = avg_item.channel;
    item_nxt.below   = !pass;
    if (!pass) begin
      item_nxt.current_q8 = '0;
    end else if (prod > PROD_W'(mcsf_pkg::CURRENT_Q8_MAX)) begin
      item_nxt.current_q8 = mcsf_pkg::CURRENT_Q8_MAX;
    end else begin
      item_nxt.current_q8 = prod[mcsf_pkg::CUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (avg_ready) begin
      valid_r <= avg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (avg_ready && avg_valid) begin
      item_r <= item_nxt;
    end
  end

  assign cur_valid = valid_r;
  assign cur_item  = item_r;

endmodule

@@ sv/mcsf_filter.sv @@
// ----------------------------------------------------------------------------
// Current filter and output register
// Per-channel first-order filter in Q16.8 and the registered result port.
// ----------------------------------------------------------------------------
module mcsf_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cur_valid,
  input  mcsf_pkg::cur_item_t              cur_item,
  output logic                             cur_ready,
  input  logic                             slow_filter,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mcsf_pkg::CH_W-1:0]        out_channel,
  output logic [mcsf_pkg::OUT_W-1:0]       out_instant_current,
  output logic [mcsf_pkg::OUT_W-1:0]       out_filtered_current,
  output logic                             out_below_off_level
);

  localparam int ECO_W  = mcsf_pkg::CUR_W + 5;
  localparam int STD_W  = mcsf_pkg::CUR_W + 4;
  localparam int QPROD_W = mcsf_pkg::MIX_W + mcsf_pkg::RECIP_W;

  logic [mcsf_pkg::CUR_W-1:0] fv_r [mcsf_pkg::NUM_CHANNELS];
  logic                       valid_r;
  logic [mcsf_pkg::CH_W-1:0]  channel_r;
  logic [mcsf_pkg::OUT_W-1:0] instant_r;
  logic [mcsf_pkg::OUT_W-1:0] filtered_r;
  logic                       below_r;

  logic                        load;
  logic [mcsf_pkg::CUR_W-1:0]  fv;
  logic [ECO_W-1:0]            mix_eco;
  logic [STD_W-1:0]            mix_std;
  logic [mcsf_pkg::MIX_W-1:0]  mix;
  logic [QPROD_W-1:0]          qprod;
  logic [mcsf_pkg::CUR_W-1:0]  fv_nxt;

  assign cur_ready = !valid_r || !out_stall;
  assign load      = cur_valid && cur_ready;

  always_comb begin
    fv      = fv_r[cur_item.channel];
    mix_eco = (ECO_W'(fv) << 4) + (ECO_W'(fv) << 1) + ECO_W'(fv) +
              ECO_W'(cur_item.current_q8);
    mix_std = (STD_W'(fv) << 3) + STD_W'(fv) + STD_W'(cur_item.current_q8);
    if (slow_filter) begin
      mix = mix_eco[ECO_W-1:2];
    end else begin
      mix = mix_std[STD_W-1:1];
    end
    qprod  = QPROD_W'(mix) * QPROD_W'(mcsf_pkg::RECIP_FIVE);
    fv_nxt = qprod[mcsf_pkg::RECIP_SHIFT +: mcsf_pkg::CUR_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mcsf_pkg::NUM_CHANNELS; k++) begin
        fv_r[k] <= '0;
      end
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        fv_r[cur_item.channel] <= fv_nxt;
      end
      if (cur_ready) begin
        valid_r <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel_r  <= cur_item.channel;
      instant_r  <= cur_item.current_q8[8 +: mcsf_pkg::OUT_W];
      filtered_r <= fv_nxt[8 +: mcsf_pkg::OUT_W];
      below_r    <= cur_item.below;
    end
  end

  assign out_valid            = valid_r;
  assign out_channel          = channel_r;
  assign out_instant_current  = instant_r;
  assign out_filtered_current = filtered_r;
  assign out_below_off_level  = below_r;

endmodule
